// ===== rtl/animation_token_frame_mapper_macros.svh =====
// Assertion macros shared by the RTL of the animation token frame mapper.
// Each macro expects clk and rst_n in scope.
`ifndef ANIMATION_TOKEN_FRAME_MAPPER_MACROS_SVH
`define ANIMATION_TOKEN_FRAME_MAPPER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ATFM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atfm: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define ATFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atfm: next-cycle check failed");

`endif

// ===== rtl/atfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atfm_pkg;

    // Longest sequence before a token forces the end.
    localparam int MaxSequence = 64;

    // ticks * 1000 / 60 == (ticks * 1092300) >> 16 for every 8-bit ticks value
    localparam int MsScale   = 1092300;
    localparam int MsShift   = 16;
    localparam int MsProdW   = 29;

    typedef struct packed {
        logic       en;         // write frame number and set seen bit
        logic       clear_all;  // drop every seen bit
        logic [7:0] addr;
        logic [5:0] frame;
    } map_wr_t;

endpackage

`default_nettype wire

// ===== rtl/atfm_frame_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atfm_frame_map
    import atfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rd_en,
    input  wire logic [7:0] rd_addr,
    input  wire logic [7:0] lookup_addr,
    input  wire map_wr_t    wr,
    output logic            seen,
    output logic [5:0]      frame
);

    logic [5:0]   frame_mem [256];
    logic [5:0]   rd_data_reg;
    logic [5:0]   bypass_reg;
    logic         bypass_hit_reg;
    logic [255:0] seen_reg;
    logic [255:0] seen_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            frame_mem[wr.addr] <= wr.frame;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
            bypass_reg  <= wr.frame;
        end
    end

    // Catch a write to the same entry in the cycle of the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    // Drop every seen bit on a start, then mark the entry being written.
    always_comb
    begin
        seen_next = wr.clear_all ? '0 : seen_reg;
        if (wr.en)
        begin
            seen_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign seen  = seen_reg[lookup_addr];
    assign frame = bypass_hit_reg ? bypass_reg : rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/animation_token_frame_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Maps animation tokens to frame numbers at one token per clock while the
// output is not stalled. The map entry is read when the token is taken into
// stage 1, and stage 1 then decides the frame, updates the map and counters
// and loads the result register. Throughput is one token per cycle when the
// output does not stall, set by the single read-modify-write of the 256-entry
// frame map; a write to the entry being read in the same cycle is forwarded.
// With start_sequence set, the token opens a fresh sequence. A zero duration
// or a token past the sequence limit ends the sequence; every later result is
// a done result carrying the frame count and sequence length until the next
// start.
module animation_token_frame_mapper
    import atfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] token,
    input  wire logic        start_sequence,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       frame_number,
    output logic             new_frame,
    output logic [2:0]       bitmap_select,
    output logic [2:0]       palette_select,
    output logic             flip_horizontal,
    output logic             flip_vertical,
    output logic [7:0]       duration_ticks,
    output logic [12:0]      duration_ms,
    output logic             sequence_done,
    output logic [6:0]       frame_count,
    output logic [6:0]       sequence_length
);

`include "animation_token_frame_mapper_macros.svh"

    logic        in_accept;
    logic        s1_advance;
    logic        s1_valid_reg;
    logic [15:0] s1_token_reg;
    logic        s1_start_reg;

    logic [6:0]  next_frame_reg;
    logic [6:0]  position_reg;
    logic        ended_reg;
    logic [6:0]  next_frame_next;
    logic [6:0]  position_next;
    logic        ended_next;

    logic        map_seen;
    logic [5:0]  map_frame;
    map_wr_t     map_wr;

    logic        out_valid_reg;
    logic [5:0]  frame_number_reg;
    logic        new_frame_reg;
    logic [15:0] token_out_reg;
    logic [12:0] duration_ms_reg;
    logic        sequence_done_reg;
    logic [6:0]  frame_count_reg;
    logic [6:0]  sequence_length_reg;

    logic [5:0]  frame_number_next;
    logic        new_frame_next;
    logic [15:0] token_out_next;
    logic [12:0] duration_ms_next;

    logic [MsProdW-1:0] ms_product;

    logic [7:0]  s1_high;
    logic [7:0]  s1_ticks;
    logic        seen_eff;
    logic        ended_eff;
    logic [6:0]  position_eff;
    logic [6:0]  next_frame_eff;
    logic        done;
    logic        fresh;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    atfm_frame_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_accept),
        .rd_addr     (token[15:8]),
        .lookup_addr (s1_high),
        .wr          (map_wr),
        .seen        (map_seen),
        .frame       (map_frame)
    );

    assign s1_high    = s1_token_reg[15:8];
    assign s1_ticks   = s1_token_reg[7:0];
    assign ms_product = MsProdW'(s1_ticks) * MsProdW'(MsScale);

    always_comb
    begin
        // A start drops the map and counters ahead of this word.
        seen_eff       = s1_start_reg ? 1'b0 : map_seen;
        ended_eff      = s1_start_reg ? 1'b0 : ended_reg;
        position_eff   = s1_start_reg ? 7'd0 : position_reg;
        next_frame_eff = s1_start_reg ? 7'd0 : next_frame_reg;

        done  = ended_eff || (s1_ticks == 8'd0) || (position_eff >= 7'(MaxSequence));
        fresh = !done && !seen_eff;

        ended_next      = done;
        position_next   = done ? position_eff : position_eff + 7'd1;
        next_frame_next = fresh ? next_frame_eff + 7'd1 : next_frame_eff;

        frame_number_next = '0;
        new_frame_next    = 1'b0;
        token_out_next    = '0;
        duration_ms_next  = '0;
        if (!done)
        begin
            frame_number_next = fresh ? next_frame_eff[5:0] : map_frame;
            new_frame_next    = fresh;
            token_out_next    = s1_token_reg;
            duration_ms_next  = ms_product[MsShift +: 13];
        end

        map_wr.en        = s1_advance && fresh;
        map_wr.clear_all = s1_advance && s1_start_reg;
        map_wr.addr      = s1_high;
        map_wr.frame     = next_frame_eff[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            next_frame_reg <= '0;
            position_reg   <= '0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg  <= 1'b1;
                next_frame_reg <= next_frame_next;
                position_reg   <= position_next;
                ended_reg      <= ended_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_token_reg <= token;
            s1_start_reg <= start_sequence;
        end
        if (s1_advance)
        begin
            frame_number_reg    <= frame_number_next;
            new_frame_reg       <= new_frame_next;
            token_out_reg       <= token_out_next;
            duration_ms_reg     <= duration_ms_next;
            sequence_done_reg   <= done;
            frame_count_reg     <= next_frame_next;
            sequence_length_reg <= position_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_number    = frame_number_reg;
    assign new_frame       = new_frame_reg;
    assign bitmap_select   = token_out_reg[10:8];
    assign palette_select  = token_out_reg[13:11];
    assign flip_horizontal = token_out_reg[14];
    assign flip_vertical   = token_out_reg[15];
    assign duration_ticks  = token_out_reg[7:0];
    assign duration_ms     = duration_ms_reg;
    assign sequence_done   = sequence_done_reg;
    assign frame_count     = frame_count_reg;
    assign sequence_length = sequence_length_reg;

    `ATFM_ASSERT_SAME(a_done_blank, out_valid && sequence_done,
        frame_number == 6'd0 && !new_frame && duration_ticks == 8'd0)
    `ATFM_ASSERT_SAME(a_new_frame_count, out_valid && new_frame,
        frame_count == 7'(frame_number) + 7'd1)
    `ATFM_ASSERT_SAME(a_frames_le_length, out_valid, frame_count <= sequence_length)
    `ATFM_ASSERT_NEXT(a_hold_stage, s1_valid_reg && !s1_advance,
        s1_valid_reg && $stable(s1_token_reg))

endmodule

`default_nettype wire
